// ===== hdl/mstw_pkg.sv =====
// ----------------------------------------------------------------------------
// mstw_pkg
// Shared types and constants for the minimum spanning tree weight block.
// ----------------------------------------------------------------------------
package mstw_pkg;

  // Graph limits and field widths that stay fixed.
  localparam int MAX_VERTICES = 32;
  localparam int VIDX_W       = $clog2(MAX_VERTICES);
  localparam int VCNT_W       = 6;
  localparam int WEIGHT_BITS  = 16;
  localparam int TOTAL_W      = 21;
  localparam int TREE_W       = 5;
  localparam int STATUS_W     = 2;

  // Status codes reported with the result.
  localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_VERTEX = 2'd2;

  // Bit positions in the error flags.
  localparam int ERR_OVF = 0;
  localparam int ERR_VTX = 1;

  // Command from the sequencer to the union-find unit.
  typedef struct packed {
    logic              init;
    logic              unite;
    logic [VIDX_W-1:0] a;
    logic [VIDX_W-1:0] b;
  } uf_cmd_t;

  // Response from the union-find unit.
  typedef struct packed {
    logic done;
    logic merged;
  } uf_rsp_t;

endpackage

// ===== hdl/minimum_spanning_tree_weight.sv =====
// ----------------------------------------------------------------------------
// minimum_spanning_tree_weight
// Kruskal minimum spanning forest over a streamed edge list.
//
//   Channel  Direction  Handshake                  Content
//   s_axis   in         s_axis_tvalid/tready       one edge item
//   m_axis   out        m_axis_tvalid/tready       forest weight and status
//   cfg      in         cfg_valid/cfg_ready        vertex_count
//
// Edges load at one item per cycle into the edge RAM. The last item starts an
// identity sweep of the parent RAM, then one round per edge in weight order
// until all stored edges are used or n_eff-1 forest edges exist, where n_eff
// is vertex_count capped at 32. A round is a scan of the edge RAM and a
// union-find join. A graph with no stored edge goes straight to the result.
// Input is stalled from the last item until the result is registered; a
// pending result holds until taken while loading of the next graph proceeds.
// Reset is synchronous.
// ----------------------------------------------------------------------------
module minimum_spanning_tree_weight #(
  parameter int MAX_EDGES = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // first_vertex, second_vertex, edge_weight
  input  logic        s_axis_tuser,   // has_edge
  input  logic        s_axis_tlast,   // last_edge
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // total_weight, tree_edges, status
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [5:0]  cfg_data        // vertex_count
);
  import mstw_pkg::*;

  localparam int AW    = $clog2(MAX_EDGES);
  localparam int CNT_W = $clog2(MAX_EDGES + 1);
  localparam int EW    = 2 * VIDX_W + WEIGHT_BITS;

  typedef enum logic [2:0] {S_LOAD, S_INIT, S_SCAN, S_JOIN, S_DONE} state_t;

  state_t                   state;
  logic [VCNT_W-1:0]        vertex_count;
  logic [VCNT_W-1:0]        n_eff;
  logic [CNT_W-1:0]         count;
  logic [1:0]               err;
  logic                     in_acc;
  logic [VIDX_W-1:0]        in_a;
  logic [VIDX_W-1:0]        in_b;
  logic [WEIGHT_BITS-1:0]   in_w;
  logic                     bad_v;
  logic                     store_we;
  logic [EW-1:0]            rd_data;
  logic [CNT_W-1:0]         scan_idx;
  logic                     rd_pend;
  logic [CNT_W-1:0]         rd_idx;
  logic                     have_prev;
  logic [WEIGHT_BITS-1:0]   prev_w;
  logic [CNT_W-1:0]         prev_idx;
  logic                     have_best;
  logic [WEIGHT_BITS-1:0]   best_w;
  logic [CNT_W-1:0]         best_idx;
  logic [VIDX_W-1:0]        best_a;
  logic [VIDX_W-1:0]        best_b;
  logic [CNT_W-1:0]         rounds;
  logic [TOTAL_W-1:0]       total;
  logic [TREE_W-1:0]        taken;
  logic [TREE_W-1:0]        taken_next;
  logic [VIDX_W-1:0]        rd_a;
  logic [VIDX_W-1:0]        rd_b;
  logic [WEIGHT_BITS-1:0]   rd_w;
  logic                     is_cand;
  logic                     is_better;
  logic                     scan_end;
  logic                     res_load;
  logic                     cmd_init;
  logic                     cmd_join;
  logic [STATUS_W-1:0]      status;
  uf_cmd_t                  uf_cmd;
  uf_rsp_t                  uf_rsp;

  // Input unpacking and edge checks.
  assign in_a   = s_axis_tdata[VIDX_W-1:0];
  assign in_b   = s_axis_tdata[2*VIDX_W-1:VIDX_W];
  assign in_w   = s_axis_tdata[EW-1:2*VIDX_W];
  assign n_eff  = (vertex_count > VCNT_W'(MAX_VERTICES)) ? VCNT_W'(MAX_VERTICES)
                                                          : vertex_count;
  assign bad_v  = ({1'b0, in_a} >= n_eff) || ({1'b0, in_b} >= n_eff);
  assign s_axis_tready = (state == S_LOAD);
  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign store_we = in_acc && s_axis_tuser && !bad_v && (count < CNT_W'(MAX_EDGES));
  assign cfg_ready = 1'b1;

  // Edge store.
  mstw_ram #(.WIDTH(EW), .DEPTH(MAX_EDGES)) u_edges (
    .clk   (clk),
    .we    (store_we),
    .waddr (count[AW-1:0]),
    .wdata ({in_w, in_b, in_a}),
    .raddr (scan_idx[AW-1:0]),
    .rdata (rd_data)
  );

  // Union-find unit.
  assign uf_cmd.init  = cmd_init;
  assign uf_cmd.unite = cmd_join;
  assign uf_cmd.a     = best_a;
  assign uf_cmd.b     = best_b;

  mstw_uf u_uf (
    .clk (clk),
    .rst (rst),
    .cmd (uf_cmd),
    .rsp (uf_rsp)
  );

  // Scan compare: next edge after the previous pick in (weight, index) order.
  assign rd_a = rd_data[VIDX_W-1:0];
  assign rd_b = rd_data[2*VIDX_W-1:VIDX_W];
  assign rd_w = rd_data[EW-1:2*VIDX_W];
  assign is_cand   = !have_prev || (rd_w > prev_w) ||
                     ((rd_w == prev_w) && (rd_idx > prev_idx));
  assign is_better = !have_best || (rd_w < best_w);
  assign scan_end  = (scan_idx == count) && !rd_pend;
  assign taken_next = uf_rsp.merged ? taken + 1'b1 : taken;

  // The result register takes a new item once it is free or being drained.
  assign res_load = (state == S_DONE) && (!m_axis_tvalid || m_axis_tready);

  // Status with overflow taking precedence.
  always_comb begin
    priority if (err[ERR_OVF]) status = ST_OVERFLOW;
    else if (err[ERR_VTX])     status = ST_BAD_VERTEX;
    else                       status = ST_OK;
  end

  // Main sequencer with registered result.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_LOAD;
      vertex_count  <= VCNT_W'(32);
      count         <= '0;
      err           <= '0;
      rd_pend       <= 1'b0;
      cmd_init      <= 1'b0;
      cmd_join      <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      cmd_init <= (state == S_LOAD) && in_acc && s_axis_tlast &&
                  !(count == '0 && !store_we);
      cmd_join <= (state == S_SCAN) && scan_end;
      if (cfg_valid && cfg_ready) begin
        vertex_count <= cfg_data;
      end
      if (res_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        S_LOAD: begin
          if (in_acc) begin
            if (s_axis_tuser) begin
              if (bad_v) begin
                err[ERR_VTX] <= 1'b1;
              end else if (count >= CNT_W'(MAX_EDGES)) begin
                err[ERR_OVF] <= 1'b1;
              end else begin
                count <= count + 1'b1;
              end
            end
            if (s_axis_tlast) begin
              total     <= '0;
              taken     <= '0;
              rounds    <= '0;
              have_prev <= 1'b0;
              if (count == '0 && !store_we) begin
                state <= S_DONE;
              end else begin
                state <= S_INIT;
              end
            end
          end
        end
        S_INIT: begin
          if (uf_rsp.done) begin
            scan_idx  <= '0;
            rd_pend   <= 1'b0;
            have_best <= 1'b0;
            state     <= S_SCAN;
          end
        end
        S_SCAN: begin
          rd_pend <= (scan_idx != count);
          rd_idx  <= scan_idx;
          if (scan_idx != count) begin
            scan_idx <= scan_idx + 1'b1;
          end
          if (rd_pend && is_cand && is_better) begin
            have_best <= 1'b1;
            best_w    <= rd_w;
            best_idx  <= rd_idx;
            best_a    <= rd_a;
            best_b    <= rd_b;
          end
          if (scan_end) begin
            have_prev <= 1'b1;
            prev_w    <= best_w;
            prev_idx  <= best_idx;
            rounds    <= rounds + 1'b1;
            state     <= S_JOIN;
          end
        end
        S_JOIN: begin
          if (uf_rsp.done) begin
            taken <= taken_next;
            if (uf_rsp.merged) begin
              total <= total + TOTAL_W'(best_w);
            end
            scan_idx  <= '0;
            rd_pend   <= 1'b0;
            have_best <= 1'b0;
            if ((n_eff != '0 && {1'b0, taken_next} == n_eff - 1'b1) ||
                rounds == count) begin
              state <= S_DONE;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_DONE: begin
          if (res_load) begin
            m_axis_tdata  <= {4'd0, status, taken, total};
            count         <= '0;
            err           <= '0;
            state         <= S_LOAD;
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  // The forest never takes more edges than rounds run.
  a_taken_le_rounds: assert property (@(posedge clk) disable iff (rst)
    (state == S_JOIN || state == S_SCAN) |-> (CNT_W'(taken) <= rounds))
    else $error("more forest edges than rounds");

  // Union-find answers only while the sequencer waits for it.
  a_uf_done_expected: assert property (@(posedge clk) disable iff (rst)
    uf_rsp.done |-> (state == S_JOIN || state == S_INIT))
    else $error("unexpected union-find response");

  // A new result appears only out of the done state.
  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(state == S_DONE))
    else $error("result without completed compute");

  // The store never counts past its capacity.
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_EDGES))
    else $error("edge count above capacity");

endmodule

// ===== hdl/mstw_ram.sv =====
// ----------------------------------------------------------------------------
// mstw_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module mstw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/mstw_uf.sv =====
// ----------------------------------------------------------------------------
// mstw_uf
// Union-find unit: parent table in RAM, identity sweep, root search and join.
// ----------------------------------------------------------------------------
module mstw_uf (
  input  logic             clk,
  input  logic             rst,
  input  mstw_pkg::uf_cmd_t cmd,
  output mstw_pkg::uf_rsp_t rsp
);
  import mstw_pkg::*;

  typedef enum logic [3:0] {
    U_IDLE, U_INIT, U_FA_RD, U_FA_CK, U_FB_RD, U_FB_CK, U_W0, U_W1, U_W2, U_W3
  } uf_state_t;

  localparam logic [VIDX_W-1:0] LAST_V = VIDX_W'(MAX_VERTICES - 1);

  uf_state_t         state;
  logic [VIDX_W-1:0] cnt;
  logic [VIDX_W-1:0] v;
  logic [VIDX_W-1:0] ea;
  logic [VIDX_W-1:0] eb;
  logic [VIDX_W-1:0] ra;
  logic [VIDX_W-1:0] rb;
  logic [VIDX_W-1:0] m;
  logic              done;
  logic              merged;
  logic              we;
  logic [VIDX_W-1:0] waddr;
  logic [VIDX_W-1:0] wdata;
  logic [VIDX_W-1:0] rdata;

  // Parent table.
  mstw_ram #(.WIDTH(VIDX_W), .DEPTH(MAX_VERTICES)) u_parent (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (v),
    .rdata (rdata)
  );

  // Both endpoints and both roots point at the smaller root.
  assign m = (ra < rb) ? ra : rb;

  // Write port selection.
  always_comb begin
    we    = 1'b1;
    waddr = m;
    wdata = m;
    unique case (state)
      U_INIT: begin
        waddr = cnt;
        wdata = cnt;
      end
      U_W0:    waddr = ea;
      U_W1:    waddr = eb;
      U_W2:    waddr = ra;
      U_W3:    waddr = rb;
      default: we = 1'b0;
    endcase
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= U_IDLE;
      done   <= 1'b0;
      merged <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        U_IDLE: begin
          if (cmd.init) begin
            cnt   <= '0;
            state <= U_INIT;
          end else if (cmd.unite) begin
            ea    <= cmd.a;
            eb    <= cmd.b;
            v     <= cmd.a;
            state <= U_FA_RD;
          end
        end
        U_INIT: begin
          cnt <= cnt + 1'b1;
          if (cnt == LAST_V) begin
            done  <= 1'b1;
            state <= U_IDLE;
          end
        end
        U_FA_RD: state <= U_FA_CK;
        U_FA_CK: begin
          if (rdata == v) begin
            ra    <= v;
            v     <= eb;
            state <= U_FB_RD;
          end else begin
            v     <= rdata;
            state <= U_FA_RD;
          end
        end
        U_FB_RD: state <= U_FB_CK;
        U_FB_CK: begin
          if (rdata == v) begin
            rb    <= v;
            state <= U_W0;
          end else begin
            v     <= rdata;
            state <= U_FB_RD;
          end
        end
        U_W0: state <= U_W1;
        U_W1: state <= U_W2;
        U_W2: state <= U_W3;
        U_W3: begin
          done   <= 1'b1;
          merged <= (ra != rb);
          state  <= U_IDLE;
        end
        default: state <= U_IDLE;
      endcase
    end
  end

  assign rsp.done   = done;
  assign rsp.merged = merged;

endmodule
